@@ design/pfre_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfre_pkg
// types and constants shared by the page frame replacement engine
// ----------------------------------------------------------------------------
package pfre_pkg;

    localparam int unsigned FIDX_W = 6;
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned POL_W  = 3;
    localparam int unsigned FIU_W  = 7;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CIDX_W = 8;
    localparam int unsigned TGT_W  = 8;

    localparam logic [CMD_W-1:0] CMD_ACCESS  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FAULT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    localparam logic [POL_W-1:0] POL_FIFO   = 3'd0;
    localparam logic [POL_W-1:0] POL_RANDOM = 3'd1;
    localparam logic [POL_W-1:0] POL_CLOCK  = 3'd2;
    localparam logic [POL_W-1:0] POL_NRU    = 3'd3;
    localparam logic [POL_W-1:0] POL_AGING  = 3'd4;
    localparam logic [POL_W-1:0] POL_WS     = 3'd5;
    localparam logic [POL_W-1:0] POL_UNUSED = 3'd7;

    localparam logic [CIDX_W-1:0] REG_POLICY   = 8'd0;
    localparam logic [CIDX_W-1:0] REG_FRAMES   = 8'd1;
    localparam logic [CIDX_W-1:0] REG_WS_WIN   = 8'd2;
    localparam logic [CIDX_W-1:0] REG_NRU_INTV = 8'd3;

    localparam logic [POL_W-1:0]  RST_POLICY   = POL_FIFO;
    localparam logic [FIU_W-1:0]  RST_FRAMES   = 7'd4;
    localparam logic [WORD_W-1:0] RST_WS_WIN   = 32'd50;
    localparam logic [WORD_W-1:0] RST_NRU_INTV = 32'd50;

    localparam int unsigned MOD_STEPS = 32;

    typedef enum logic [1:0] {
        CELL_NONE,
        CELL_ACCESS,
        CELL_RELEASE,
        CELL_GRANT
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic              wr;
        logic              age_wr;
        logic [WORD_W-1:0] age_val;
        logic [WORD_W-1:0] now;
        logic              tok_load;
        logic              tok_shift;
        logic              tok_clr_ref;
        logic              ws_touch;
        logic              clr_ref_all;
        logic              age_all;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_QREAD,
        ST_MOD,
        ST_AGE,
        ST_SCAN,
        ST_VICT,
        ST_GRANT,
        ST_FIN
    } state_t;

endpackage
`default_nettype wire

@@ design/pfre_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfre_cell
// one frame: referenced and dirty bits, age or last use, and the scan token
// ----------------------------------------------------------------------------
module pfre_cell (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire pfre_pkg::cell_ctrl_t  ctrl,
    input  wire                        sel,
    input  wire                        live,
    input  wire                        start,
    input  wire                        tok_in,
    output logic                       tok,
    output logic                       ref_bit,
    output logic                       dirty_bit,
    output logic [pfre_pkg::WORD_W-1:0] age
);

    logic                        ref_reg, ref_next;
    logic                        dirty_reg, dirty_next;
    logic [pfre_pkg::WORD_W-1:0] age_reg, age_next;
    logic                        tok_reg, tok_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg   <= 1'b0;
            dirty_reg <= 1'b0;
            age_reg   <= '0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            ref_reg   <= ref_next;
            dirty_reg <= dirty_next;
            age_reg   <= age_next;
            tok_reg   <= tok_next;
        end
    end

    always_comb
    begin
        ref_next   = ref_reg;
        dirty_next = dirty_reg;
        age_next   = age_reg;
        tok_next   = tok_reg;
        if (ctrl.clr_ref_all && live)
        begin
            ref_next = 1'b0;
        end
        if (ctrl.age_all && live)
        begin
            age_next = {ref_reg, age_reg[pfre_pkg::WORD_W-1:1]};
            ref_next = 1'b0;
        end
        if (tok_reg && ctrl.tok_clr_ref)
        begin
            ref_next = 1'b0;
        end
        if (tok_reg && ctrl.ws_touch && ref_reg)
        begin
            age_next = ctrl.now;
            ref_next = 1'b0;
        end
        if (sel)
        begin
            case (ctrl.op)
                pfre_pkg::CELL_ACCESS:
                begin
                    ref_next = 1'b1;
                    if (ctrl.wr)
                    begin
                        dirty_next = 1'b1;
                    end
                end
                pfre_pkg::CELL_RELEASE:
                begin
                    ref_next   = 1'b0;
                    dirty_next = 1'b0;
                end
                pfre_pkg::CELL_GRANT:
                begin
                    ref_next   = 1'b1;
                    dirty_next = ctrl.wr;
                    if (ctrl.age_wr)
                    begin
                        age_next = ctrl.age_val;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (ctrl.tok_load)
        begin
            tok_next = start;
        end
        else if (ctrl.tok_shift)
        begin
            tok_next = tok_in;
        end
    end

    assign tok       = tok_reg;
    assign ref_bit   = ref_reg;
    assign dirty_bit = dirty_reg;
    assign age       = age_reg;

endmodule
`default_nettype wire

@@ design/pfre_mod.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfre_mod
// bit-serial remainder of a 32-bit value by the frame count
// ----------------------------------------------------------------------------
module pfre_mod #(
    parameter int unsigned NW = 7
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire  [pfre_pkg::WORD_W-1:0] dividend,
    input  wire  [NW-1:0]               divisor,
    output logic                        done,
    output logic [NW-1:0]               rem
);

    localparam int unsigned CW = $clog2(pfre_pkg::MOD_STEPS);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [pfre_pkg::WORD_W-1:0] dvd_reg, dvd_next;
    logic [NW-1:0]               rem_reg, rem_next;
    logic [NW:0]                 trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[pfre_pkg::WORD_W-1]};
        if (trial >= {1'b0, divisor})
        begin
            trial = trial - {1'b0, divisor};
        end
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = trial[NW-1:0];
            dvd_next = {dvd_reg[pfre_pkg::WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(pfre_pkg::MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

@@ design/page_frame_replacement_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_replacement_engine
// physical frame allocator with fifo, random, clock, nru, aging and
// working-set replacement over a chain of per-frame cells
// ----------------------------------------------------------------------------
// Items are handled one at a time. A fault served from the release queue
// and a random eviction each run the 32-step remainder unit. Clock, nru,
// aging and working-set evictions pass a token down the row of frame cells,
// one frame per cycle; aging first updates the ages of all frames.
// The next command is taken while the previous result waits at the output.
// ----------------------------------------------------------------------------
module page_frame_replacement_engine #(
    parameter int unsigned FRAMES = 64
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [pfre_pkg::CIDX_W-1:0]  cfg_index,
    input  wire  [pfre_pkg::WORD_W-1:0]  cfg_data,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [pfre_pkg::CMD_W-1:0]   cmd,
    input  wire  [pfre_pkg::FIDX_W-1:0]  frame_index,
    input  wire                          is_write,
    input  wire  [pfre_pkg::WORD_W-1:0]  instr_count,
    input  wire  [pfre_pkg::WORD_W-1:0]  random_value,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [pfre_pkg::FIDX_W-1:0]  chosen_frame,
    output logic                         from_free,
    output logic                         victim_dirty
);

    localparam int unsigned IW = $clog2(FRAMES);
    localparam int unsigned NW = $clog2(FRAMES + 1);

    pfre_pkg::state_t state_reg, state_next;
    pfre_pkg::cell_ctrl_t ctrl;

    logic [pfre_pkg::POL_W-1:0]  policy_reg;
    logic [pfre_pkg::FIU_W-1:0]  fiu_reg;
    logic [pfre_pkg::WORD_W-1:0] ws_win_reg;
    logic [pfre_pkg::WORD_W-1:0] nru_intv_reg;

    logic [pfre_pkg::CMD_W-1:0]  cmd_reg;
    logic [pfre_pkg::FIDX_W-1:0] fi_reg;
    logic                        wr_reg;
    logic [pfre_pkg::WORD_W-1:0] now_reg;
    logic [pfre_pkg::WORD_W-1:0] rnd_reg;

    logic [IW-1:0] hand_reg, hand_next;
    logic [NW-1:0] fresh_reg, fresh_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [NW-1:0] count_reg, count_next;
    logic [pfre_pkg::WORD_W-1:0] last_nru_reg, last_nru_next;

    logic [IW-1:0] j_reg, j_next;
    logic [NW-1:0] k_reg, k_next;
    logic [IW-1:0] v_reg, v_next;
    logic [IW-1:0] gnt_reg, gnt_next;
    logic [2:0]    best_cls_reg, best_cls_next;
    logic [pfre_pkg::WORD_W-1:0] best_age_reg, best_age_next;
    logic          src_q_reg, src_q_next;

    logic [pfre_pkg::FIDX_W-1:0] res_frame_reg, res_frame_next;
    logic                        res_ff_reg, res_ff_next;
    logic                        res_vd_reg, res_vd_next;

    logic                        out_valid_reg, out_valid_next;
    logic [pfre_pkg::FIDX_W-1:0] out_frame_reg, out_frame_next;
    logic                        out_ff_reg, out_ff_next;
    logic                        out_vd_reg, out_vd_next;

    logic [IW-1:0] q_mem [FRAMES];
    logic [IW-1:0] q_rd_reg;
    logic          q_push;
    logic          q_pop;

    logic          mod_start;
    logic [pfre_pkg::WORD_W-1:0] mod_dvd;
    logic          mod_done;
    logic [NW-1:0] mod_rem;

    logic [NW-1:0] n_w;
    logic [IW-1:0] h_eff;
    logic [pfre_pkg::TGT_W-1:0] tgt;
    logic [FRAMES-1:0] sel_vec, start_vec, last_vec, tok_vec, tok_in_vec;
    logic [FRAMES-1:0] live_vec;
    logic [FRAMES-1:0] ref_vec, dirty_vec;
    logic [pfre_pkg::WORD_W-1:0] age_arr [FRAMES];
    logic          tr, td;
    logic [pfre_pkg::WORD_W-1:0] ta;
    logic [2:0]    cls;
    logic          j_last;
    logic          k_last;
    logic          fi_in_range;
    logic          rel_ok;
    logic          in_xfer;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == pfre_pkg::ST_IDLE);
    assign in_xfer   = in_valid && in_ready;

    always_comb
    begin
        if (fiu_reg == '0)
        begin
            n_w = NW'(1);
        end
        else if (32'(fiu_reg) > FRAMES)
        begin
            n_w = NW'(FRAMES);
        end
        else
        begin
            n_w = NW'(fiu_reg);
        end
    end

    assign h_eff       = (32'(hand_reg) < 32'(n_w)) ? hand_reg : '0;
    assign j_last      = (32'(j_reg) + 32'd1 == 32'(n_w));
    assign k_last      = (32'(k_reg) + 32'd1 == 32'(n_w));
    assign fi_in_range = (32'(fi_reg) < 32'(n_w));
    assign rel_ok      = fi_in_range && (32'(fi_reg) < 32'(fresh_reg))
                         && (32'(count_reg) < FRAMES);

    always_comb
    begin
        case (state_reg)
            pfre_pkg::ST_DISPATCH: tgt = pfre_pkg::TGT_W'(fi_reg);
            pfre_pkg::ST_VICT:     tgt = pfre_pkg::TGT_W'(v_reg);
            default:               tgt = pfre_pkg::TGT_W'(gnt_reg);
        endcase
    end

    always_comb
    begin
        tr = 1'b0;
        td = 1'b0;
        ta = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            sel_vec[i]   = (tgt == pfre_pkg::TGT_W'(i));
            start_vec[i] = (32'(h_eff) == i);
            last_vec[i]  = (32'(n_w) == i + 1);
            live_vec[i]  = (32'(n_w) > i);
            tr = tr | (tok_vec[i] & ref_vec[i]);
            td = td | (tok_vec[i] & dirty_vec[i]);
            ta = ta | (age_arr[i] & {pfre_pkg::WORD_W{tok_vec[i]}});
        end
        tok_in_vec = {tok_vec[FRAMES-2:0] & ~last_vec[FRAMES-2:0], |(tok_vec & last_vec)};
    end

    assign cls = {1'b0, tr, td};

    for (genvar g = 0; g < FRAMES; g++)
    begin : g_cell
        pfre_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .sel       (sel_vec[g]),
            .live      (live_vec[g]),
            .start     (start_vec[g]),
            .tok_in    (tok_in_vec[g]),
            .tok       (tok_vec[g]),
            .ref_bit   (ref_vec[g]),
            .dirty_bit (dirty_vec[g]),
            .age       (age_arr[g])
        );
    end

    pfre_mod #(
        .NW (NW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dvd),
        .divisor  (n_w),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg   <= pfre_pkg::RST_POLICY;
            fiu_reg      <= pfre_pkg::RST_FRAMES;
            ws_win_reg   <= pfre_pkg::RST_WS_WIN;
            nru_intv_reg <= pfre_pkg::RST_NRU_INTV;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pfre_pkg::REG_POLICY:   policy_reg   <= cfg_data[pfre_pkg::POL_W-1:0];
                pfre_pkg::REG_FRAMES:   fiu_reg      <= cfg_data[pfre_pkg::FIU_W-1:0];
                pfre_pkg::REG_WS_WIN:   ws_win_reg   <= cfg_data;
                pfre_pkg::REG_NRU_INTV: nru_intv_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // release queue
    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem[tail_reg] <= IW'(fi_reg);
        end
        if (q_pop)
        begin
            q_rd_reg <= q_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg <= cmd;
            fi_reg  <= frame_index;
            wr_reg  <= is_write;
            now_reg <= instr_count;
            rnd_reg <= random_value;
        end
        j_reg         <= j_next;
        k_reg         <= k_next;
        v_reg         <= v_next;
        gnt_reg       <= gnt_next;
        best_cls_reg  <= best_cls_next;
        best_age_reg  <= best_age_next;
        src_q_reg     <= src_q_next;
        res_frame_reg <= res_frame_next;
        res_ff_reg    <= res_ff_next;
        res_vd_reg    <= res_vd_next;
        out_frame_reg <= out_frame_next;
        out_ff_reg    <= out_ff_next;
        out_vd_reg    <= out_vd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfre_pkg::ST_IDLE;
            hand_reg      <= '0;
            fresh_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            last_nru_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hand_reg      <= hand_next;
            fresh_reg     <= fresh_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            last_nru_reg  <= last_nru_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        hand_next      = hand_reg;
        fresh_next     = fresh_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        last_nru_next  = last_nru_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        v_next         = v_reg;
        gnt_next       = gnt_reg;
        best_cls_next  = best_cls_reg;
        best_age_next  = best_age_reg;
        src_q_next     = src_q_reg;
        res_frame_next = res_frame_reg;
        res_ff_next    = res_ff_reg;
        res_vd_next    = res_vd_reg;
        out_valid_next = out_valid_reg;
        out_frame_next = out_frame_reg;
        out_ff_next    = out_ff_reg;
        out_vd_next    = out_vd_reg;
        q_push         = 1'b0;
        q_pop          = 1'b0;
        mod_start      = 1'b0;
        mod_dvd        = rnd_reg;
        ctrl           = '0;
        ctrl.now       = now_reg;
        ctrl.wr        = wr_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pfre_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = pfre_pkg::ST_DISPATCH;
                end
            end
            pfre_pkg::ST_DISPATCH:
            begin
                res_frame_next = fi_reg;
                res_ff_next    = 1'b0;
                res_vd_next    = 1'b0;
                state_next     = pfre_pkg::ST_FIN;
                case (cmd_reg)
                    pfre_pkg::CMD_ACCESS:
                    begin
                        if (fi_in_range)
                        begin
                            ctrl.op = pfre_pkg::CELL_ACCESS;
                        end
                    end
                    pfre_pkg::CMD_RELEASE:
                    begin
                        if (rel_ok)
                        begin
                            ctrl.op    = pfre_pkg::CELL_RELEASE;
                            q_push     = 1'b1;
                            tail_next  = (32'(tail_reg) == FRAMES - 1) ? '0 : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    pfre_pkg::CMD_FAULT:
                    begin
                        if (fresh_reg < n_w)
                        begin
                            gnt_next       = IW'(fresh_reg);
                            res_frame_next = pfre_pkg::FIDX_W'(fresh_reg);
                            res_ff_next    = 1'b1;
                            fresh_next     = fresh_reg + 1'b1;
                            state_next     = pfre_pkg::ST_GRANT;
                        end
                        else if (count_reg != '0)
                        begin
                            q_pop       = 1'b1;
                            head_next   = (32'(head_reg) == FRAMES - 1) ? '0 : head_reg + 1'b1;
                            count_next  = count_reg - 1'b1;
                            res_ff_next = 1'b1;
                            src_q_next  = 1'b1;
                            state_next  = pfre_pkg::ST_QREAD;
                        end
                        else
                        begin
                            j_next        = h_eff;
                            k_next        = '0;
                            v_next        = h_eff;
                            best_cls_next = 3'd4;
                            case (policy_reg)
                                pfre_pkg::POL_RANDOM:
                                begin
                                    mod_start  = 1'b1;
                                    src_q_next = 1'b0;
                                    state_next = pfre_pkg::ST_MOD;
                                end
                                pfre_pkg::POL_AGING:
                                begin
                                    state_next = pfre_pkg::ST_AGE;
                                end
                                pfre_pkg::POL_CLOCK, pfre_pkg::POL_NRU, pfre_pkg::POL_WS:
                                begin
                                    ctrl.tok_load = 1'b1;
                                    state_next    = pfre_pkg::ST_SCAN;
                                end
                                default:
                                begin
                                    state_next = pfre_pkg::ST_VICT;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            pfre_pkg::ST_QREAD:
            begin
                mod_start  = 1'b1;
                mod_dvd    = pfre_pkg::WORD_W'(q_rd_reg);
                state_next = pfre_pkg::ST_MOD;
            end
            pfre_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    if (src_q_reg)
                    begin
                        gnt_next       = IW'(mod_rem);
                        res_frame_next = pfre_pkg::FIDX_W'(mod_rem);
                        state_next     = pfre_pkg::ST_GRANT;
                    end
                    else
                    begin
                        v_next     = IW'(mod_rem);
                        state_next = pfre_pkg::ST_VICT;
                    end
                end
            end
            pfre_pkg::ST_AGE:
            begin
                ctrl.age_all  = 1'b1;
                ctrl.tok_load = 1'b1;
                state_next    = pfre_pkg::ST_SCAN;
            end
            pfre_pkg::ST_SCAN:
            begin
                ctrl.tok_shift = 1'b1;
                j_next         = j_last ? '0 : j_reg + 1'b1;
                k_next         = k_reg + 1'b1;
                case (policy_reg)
                    pfre_pkg::POL_CLOCK:
                    begin
                        if (tr)
                        begin
                            ctrl.tok_clr_ref = 1'b1;
                            if (k_reg == n_w)
                            begin
                                state_next = pfre_pkg::ST_VICT;
                            end
                        end
                        else
                        begin
                            v_next     = j_reg;
                            state_next = pfre_pkg::ST_VICT;
                        end
                    end
                    pfre_pkg::POL_NRU:
                    begin
                        if (cls < best_cls_reg)
                        begin
                            best_cls_next = cls;
                            v_next        = j_reg;
                        end
                        if (cls == 3'd0 || k_last)
                        begin
                            state_next = pfre_pkg::ST_VICT;
                        end
                    end
                    pfre_pkg::POL_AGING:
                    begin
                        if (k_reg == '0 || ta < best_age_reg)
                        begin
                            best_age_next = ta;
                            v_next        = j_reg;
                        end
                        if (k_last)
                        begin
                            state_next = pfre_pkg::ST_VICT;
                        end
                    end
                    default:
                    begin
                        ctrl.ws_touch = 1'b1;
                        if (tr)
                        begin
                            if (k_reg == '0)
                            begin
                                best_age_next = now_reg;
                            end
                            if (k_last)
                            begin
                                state_next = pfre_pkg::ST_VICT;
                            end
                        end
                        else if (now_reg - ta >= ws_win_reg)
                        begin
                            v_next     = j_reg;
                            state_next = pfre_pkg::ST_VICT;
                        end
                        else
                        begin
                            if (k_reg == '0 || ta < best_age_reg)
                            begin
                                best_age_next = ta;
                                v_next        = j_reg;
                            end
                            if (k_last)
                            begin
                                state_next = pfre_pkg::ST_VICT;
                            end
                        end
                    end
                endcase
            end
            pfre_pkg::ST_VICT:
            begin
                // the random policy leaves the hand where it is
                if (policy_reg != pfre_pkg::POL_RANDOM)
                begin
                    hand_next = (32'(v_reg) + 32'd1 == 32'(n_w)) ? '0 : v_reg + 1'b1;
                end
                gnt_next       = v_reg;
                res_frame_next = pfre_pkg::FIDX_W'(v_reg);
                res_vd_next    = |(sel_vec & dirty_vec);
                if (policy_reg == pfre_pkg::POL_NRU && now_reg - last_nru_reg >= nru_intv_reg)
                begin
                    ctrl.clr_ref_all = 1'b1;
                    last_nru_next    = now_reg;
                end
                state_next = pfre_pkg::ST_GRANT;
            end
            pfre_pkg::ST_GRANT:
            begin
                ctrl.op = pfre_pkg::CELL_GRANT;
                if (policy_reg == pfre_pkg::POL_AGING)
                begin
                    ctrl.age_wr  = 1'b1;
                    ctrl.age_val = '0;
                end
                else if (policy_reg == pfre_pkg::POL_WS)
                begin
                    ctrl.age_wr  = 1'b1;
                    ctrl.age_val = now_reg;
                end
                state_next = pfre_pkg::ST_FIN;
            end
            pfre_pkg::ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_frame_next = res_frame_reg;
                    out_ff_next    = res_ff_reg;
                    out_vd_next    = res_vd_reg;
                    state_next     = pfre_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfre_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign chosen_frame = out_frame_reg;
    assign from_free    = out_ff_reg;
    assign victim_dirty = out_vd_reg;

    a_scan_token: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfre_pkg::ST_SCAN) |-> $onehot(tok_vec))
        else $error("scan token lost or duplicated");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= FRAMES)
        else $error("release queue overflow");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fresh_reg) <= FRAMES)
        else $error("fresh count beyond frame count");

    a_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ff_reg) |-> !out_vd_reg)
        else $error("free frame reported with write-back");

endmodule
`default_nettype wire

@@ test/page_frame_replacement_engine_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_replacement_engine_tb
// drives access, fault and release commands through every replacement policy
// and several frame counts, predicts each frame grant, and checks every result
// ----------------------------------------------------------------------------
module page_frame_replacement_engine_tb;

    localparam int NF = 64;

    typedef struct packed {
        logic [pfre_pkg::CMD_W-1:0]  cmd;
        logic [pfre_pkg::FIDX_W-1:0] fidx;
        logic                        wr;
        logic [pfre_pkg::WORD_W-1:0] now;
        logic [pfre_pkg::WORD_W-1:0] rnd;
    } req_t;

    typedef struct packed {
        logic [pfre_pkg::FIDX_W-1:0] frame;
        logic                        ffree;
        logic                        vdirty;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic [pfre_pkg::CIDX_W-1:0] cfg_index = '0;
    logic [pfre_pkg::WORD_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic [pfre_pkg::CMD_W-1:0] cmd = '0;
    logic [pfre_pkg::FIDX_W-1:0] frame_index = '0;
    logic is_write = 1'b0;
    logic [pfre_pkg::WORD_W-1:0] instr_count = '0;
    logic [pfre_pkg::WORD_W-1:0] random_value = '0;
    logic out_ready = 1'b0;
    wire cfg_ready, in_ready, out_valid, from_free, victim_dirty;
    wire [pfre_pkg::FIDX_W-1:0] chosen_frame;

    page_frame_replacement_engine dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .frame_index(frame_index), .is_write(is_write),
        .instr_count(instr_count), .random_value(random_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .chosen_frame(chosen_frame), .from_free(from_free),
        .victim_dirty(victim_dirty)
    );

    always #10 clk = ~clk;

    // predictor state
    bit          ref_b [NF];
    bit          dirty_b [NF];
    logic [31:0] age [NF];
    int unsigned hand_p, fresh_p, rq_head, rq_tail, rq_cnt;
    int unsigned relq [NF];
    logic [31:0] last_nru;
    logic [2:0]  pol_r;
    logic [6:0]  nfr_r;
    logic [31:0] win_r, intv_r;

    req_t   pending_reqs[$];
    grant_t expected_grants[$];
    int     errors = 0;
    int     accepted = 0;
    int     faults_seen = 0;
    int     idle_cycles = 0;
    bit     hold_long = 0;
    bit     in_taken = 0;

    function automatic void add_req(req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic int unsigned choose_victim(int unsigned n, logic [31:0] now,
                                                  logic [31:0] rnd);
        int unsigned h, v, j, best, c;
        bit found;
        h = (hand_p < n) ? hand_p : 0;
        v = h;
        case (pol_r)
            pfre_pkg::POL_RANDOM: return rnd % n;
            pfre_pkg::POL_CLOCK:
                for (int k = 0; k <= n; k++) begin
                    j = (h + k) % n;
                    if (ref_b[j]) ref_b[j] = 0;
                    else begin
                        v = j;
                        break;
                    end
                end
            pfre_pkg::POL_NRU:
            begin
                best = 4;
                for (int k = 0; k < n; k++) begin
                    j = (h + k) % n;
                    c = ref_b[j] * 2 + dirty_b[j];
                    if (c < best) begin
                        best = c;
                        v = j;
                    end
                    if (c == 0) break;
                end
                if (32'(now - last_nru) >= intv_r) begin
                    for (int i = 0; i < n; i++) ref_b[i] = 0;
                    last_nru = now;
                end
            end
            pfre_pkg::POL_AGING:
            begin
                for (int i = 0; i < n; i++) begin
                    age[i] = (age[i] >> 1) + (32'(ref_b[i]) << 31);
                    ref_b[i] = 0;
                end
                for (int k = 0; k < n; k++) begin
                    j = (h + k) % n;
                    if (age[j] < age[v]) v = j;
                end
            end
            pfre_pkg::POL_WS:
            begin
                found = 0;
                for (int k = 0; k < n && !found; k++) begin
                    j = (h + k) % n;
                    if (ref_b[j]) begin
                        age[j] = now;
                        ref_b[j] = 0;
                    end else if (32'(now - age[j]) >= win_r) begin
                        v = j;
                        found = 1;
                    end else if (age[j] < age[v]) v = j;
                end
            end
            default: v = h;
        endcase
        hand_p = (v + 1) % n;
        return v;
    endfunction

    function automatic grant_t predict_grant(req_t r);
        grant_t g;
        int unsigned n, f;
        n = (nfr_r < 1) ? 1 : (nfr_r > NF ? NF : nfr_r);
        g.frame = r.fidx;
        g.ffree = 0;
        g.vdirty = 0;
        f = r.fidx;
        if (r.cmd == pfre_pkg::CMD_ACCESS) begin
            if (f < n) begin
                ref_b[f] = 1;
                if (r.wr) dirty_b[f] = 1;
            end
        end else if (r.cmd == pfre_pkg::CMD_FAULT) begin
            if (fresh_p < n) begin
                f = fresh_p;
                fresh_p++;
                g.ffree = 1;
            end else if (rq_cnt > 0) begin
                f = relq[rq_head] % n;
                rq_head = (rq_head + 1) % NF;
                rq_cnt--;
                g.ffree = 1;
            end else begin
                f = choose_victim(n, r.now, r.rnd);
                g.vdirty = dirty_b[f];
            end
            g.frame = 6'(f);
            ref_b[f] = 1;
            dirty_b[f] = r.wr;
            if (pol_r == pfre_pkg::POL_AGING) age[f] = 0;
            else if (pol_r == pfre_pkg::POL_WS) age[f] = r.now;
        end else if (r.cmd == pfre_pkg::CMD_RELEASE) begin
            if (f < n && f < fresh_p && rq_cnt < NF) begin
                relq[rq_tail] = f;
                rq_tail = (rq_tail + 1) % NF;
                rq_cnt++;
                ref_b[f] = 0;
                dirty_b[f] = 0;
            end
        end
        return g;
    endfunction

    task automatic write_reg(input logic [pfre_pkg::CIDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            pfre_pkg::REG_POLICY:   pol_r = val[2:0];
            pfre_pkg::REG_FRAMES:   nfr_r = val[6:0];
            pfre_pkg::REG_WS_WIN:   win_r = val;
            pfre_pkg::REG_NRU_INTV: intv_r = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending_reqs.size() != 0 || expected_grants.size() != 0 || in_valid)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic req_t make_req(logic [1:0] c, logic [5:0] f, bit w);
        req_t r;
        r.cmd = c;
        r.fidx = f;
        r.wr = w;
        r.now = $urandom;
        r.rnd = $urandom;
        return r;
    endfunction

    // random phase: accesses to live frames, faults, some releases, unknown commands and accesses to any frame index
    task automatic queue_random(int cnt, int unsigned n);
        int unsigned sel;
        req_t r;
        logic [31:0] t;
        t = $urandom;
        for (int i = 0; i < cnt; i++) begin
            sel = $urandom_range(0, 99);
            r = make_req(pfre_pkg::CMD_ACCESS, 6'($urandom_range(0, n - 1)),
                         1'($urandom_range(0, 1)));
            t = t + $urandom_range(0, 40);
            r.now = ($urandom_range(0, 9) == 0) ? $urandom : t;
            if (sel < 40) r.cmd = pfre_pkg::CMD_FAULT;
            else if (sel < 52) r.cmd = pfre_pkg::CMD_RELEASE;
            else if (sel < 56) r.cmd = pfre_pkg::CMD_UNUSED;
            else if (sel < 60) r.fidx = 6'($urandom);
            add_req(r);
        end
    endtask

    // input transfer seen at the last rising edge
    always @(posedge clk) in_taken <= in_valid && in_ready;

    // driver
    int unsigned gap = 0;
    always @(negedge clk) begin
        if (!rst_n) in_valid <= 1'b0;
        else if (in_valid && !in_taken) ;
        else if (gap != 0) begin
            gap <= gap - 1;
            in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
            in_valid <= 1'b1;
            cmd <= pending_reqs[0].cmd;
            frame_index <= pending_reqs[0].fidx;
            is_write <= pending_reqs[0].wr;
            instr_count <= pending_reqs[0].now;
            random_value <= pending_reqs[0].rnd;
            pending_reqs.delete(0);
            gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
        end else in_valid <= 1'b0;
    end

    // receiver stall
    int unsigned stall = 0;
    int unsigned long_cnt = 0;
    always @(negedge clk) begin
        if (hold_long) begin
            out_ready <= 1'b0;
            long_cnt <= long_cnt + 1;
        end else if (stall != 0) begin
            stall <= stall - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (out_valid && out_ready)
                stall <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
        end
    end

    // monitor
    always @(posedge clk) begin
        grant_t e;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                expected_grants.insert(expected_grants.size(),
                                       predict_grant({cmd, frame_index, is_write,
                                                      instr_count, random_value}));
                accepted++;
                if (cmd == pfre_pkg::CMD_FAULT) faults_seen++;
            end
            if (out_valid && out_ready) begin
                if (expected_grants.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end else begin
                    e = expected_grants[0];
                    expected_grants.delete(0);
                    if (chosen_frame !== e.frame) begin
                        $error("chosen_frame expected %0d actual %0d", e.frame, chosen_frame);
                        errors++;
                    end
                    if (from_free !== e.ffree) begin
                        $error("from_free expected %0d actual %0d", e.ffree, from_free);
                        errors++;
                    end
                    if (victim_dirty !== e.vdirty) begin
                        $error("victim_dirty expected %0d actual %0d", e.vdirty, victim_dirty);
                        errors++;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready) || hold_long)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int unsigned sizes [8];
        logic [2:0] pols [7];
        sizes = '{1, 2, 3, 4, 8, 17, 64, 127};
        pols = '{pfre_pkg::POL_FIFO, pfre_pkg::POL_RANDOM, pfre_pkg::POL_CLOCK,
                 pfre_pkg::POL_NRU, pfre_pkg::POL_AGING, pfre_pkg::POL_WS,
                 pfre_pkg::POL_UNUSED};
        for (int i = 0; i < NF; i++) begin
            ref_b[i] = 0;
            dirty_b[i] = 0;
            age[i] = 0;
            relq[i] = 0;
        end
        hand_p = 0; fresh_p = 0; rq_head = 0; rq_tail = 0; rq_cnt = 0;
        last_nru = 0;
        pol_r = pfre_pkg::RST_POLICY; nfr_r = pfre_pkg::RST_FRAMES;
        win_r = pfre_pkg::RST_WS_WIN; intv_r = pfre_pkg::RST_NRU_INTV;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part under the reset settings
        add_req(make_req(pfre_pkg::CMD_FAULT, 6'd63, 1));
        add_req(make_req(pfre_pkg::CMD_ACCESS, 6'd0, 1));
        add_req(make_req(pfre_pkg::CMD_ACCESS, 6'd63, 1));
        add_req(make_req(pfre_pkg::CMD_RELEASE, 6'd2, 0));
        add_req(make_req(pfre_pkg::CMD_RELEASE, 6'd0, 0));
        add_req(make_req(pfre_pkg::CMD_RELEASE, 6'd0, 0));
        add_req(make_req(pfre_pkg::CMD_UNUSED, 6'd42, 1));
        for (int i = 0; i < 6; i++)
            add_req(make_req(pfre_pkg::CMD_FAULT, 6'($urandom), i[0]));
        add_req(make_req(pfre_pkg::CMD_ACCESS, 6'd1, 0));
        add_req(make_req(pfre_pkg::CMD_FAULT, 6'd0, 0));
        drain();

        // queue commands while the result side holds off
        hold_long = 1;
        queue_random(12, 4);
        while (long_cnt < 300) @(posedge clk);
        hold_long = 0;
        drain();

        for (int p = 0; p < 7; p++) begin
            write_reg(pfre_pkg::REG_POLICY, 32'(pols[p]));
            write_reg(pfre_pkg::REG_FRAMES, sizes[$urandom_range(0, 7)]);
            write_reg(pfre_pkg::REG_WS_WIN, (p % 2) ? 32'hFFFF_FFFF : $urandom_range(0, 60));
            write_reg(pfre_pkg::REG_NRU_INTV, (p % 3 == 0) ? 32'd0 : $urandom_range(1, 80));
            queue_random(75, (nfr_r == 0) ? 1 : (nfr_r > NF ? NF : nfr_r));
            drain();
            write_reg(pfre_pkg::REG_FRAMES, (p == 3) ? 32'd0 : 32'($urandom_range(2, 8)));
            queue_random(75, (nfr_r == 0) ? 1 : nfr_r);
            drain();
        end
        write_reg(pfre_pkg::REG_FRAMES, 32'd64);
        write_reg(pfre_pkg::REG_WS_WIN, 32'd0);
        write_reg(pfre_pkg::REG_POLICY, 32'(pfre_pkg::POL_WS));
        queue_random(40, 64);
        drain();

        $display("covered %0d transfers, %0d faults, 7 policy settings, frame counts 0..127",
                 accepted, faults_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
